### hdl/pvt_pkg.sv
// Package for the perspective vertex transform: register map, reset values
// and fixed field widths. No dependencies.
package pvt_pkg;

  localparam int COEF_W   = 16;  // Q2.14 rotation coefficients
  localparam int FRAC_W   = 14;  // fraction bits of the coefficients
  localparam int SCREEN_W = 13;  // viewport size registers
  localparam int PIXEL_W  = 16;  // saturated pixel outputs
  localparam int QUOT_W   = 16;  // quotient bits per divider
  localparam int DATA_W   = 32;  // configuration data bus
  localparam int ADDR_W   = 5;   // configuration byte address

  typedef enum logic [2:0] {
    REG_COS      = 3'd0,
    REG_SIN      = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_CENTER_Z = 3'd4,
    REG_WIDTH    = 3'd5,
    REG_HEIGHT   = 3'd6,
    REG_NONE     = 3'd7
  } reg_index_t;

  localparam logic [COEF_W-1:0]   COS_RESET    = 16'd16384;
  localparam logic [COEF_W-1:0]   SIN_RESET    = 16'd0;
  localparam int                  CENTER_Z_RST = 10240;
  localparam logic [SCREEN_W-1:0] WIDTH_RESET  = 13'd500;
  localparam logic [SCREEN_W-1:0] HEIGHT_RESET = 13'd500;

  localparam logic signed [PIXEL_W-1:0] PIXEL_MAX = 16'sh7FFF;
  localparam logic signed [PIXEL_W-1:0] PIXEL_MIN = 16'sh8000;

endpackage

### hdl/pvt_vertex_if.sv
// Channel interfaces of the perspective vertex transform: vertex beats in,
// pixel beats out. Uses pvt_pkg for the pixel width.
interface pvt_vertex_if #(parameter int COORD_WIDTH = 16) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex_x;
  logic signed [COORD_WIDTH-1:0] vertex_y;
  logic signed [COORD_WIDTH-1:0] vertex_z;

  modport source (output valid, vertex_x, vertex_y, vertex_z, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, output ready);
endinterface

interface pvt_pixel_if ();
  logic                                 valid;
  logic                                 ready;
  logic signed [pvt_pkg::PIXEL_W-1:0]   pixel_x;
  logic signed [pvt_pkg::PIXEL_W-1:0]   pixel_y;
  logic                                 depth_invalid;

  modport source (output valid, pixel_x, pixel_y, depth_invalid, input ready);
  modport sink   (input valid, pixel_x, pixel_y, depth_invalid, output ready);
endinterface

### hdl/pvt_rotate.sv
// Rotation stages 1-3: center offset, four coefficient products, floor
// shift and center add. Uses pvt_pkg for coefficient widths.
module pvt_rotate #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic signed [COORD_WIDTH-1:0]         vx,
  input  logic signed [COORD_WIDTH-1:0]         vy,
  input  logic signed [COORD_WIDTH-1:0]         vz,
  input  logic signed [COORD_WIDTH-1:0]         cx,
  input  logic signed [COORD_WIDTH-1:0]         cz,
  input  logic signed [pvt_pkg::COEF_W-1:0]     cosv,
  input  logic signed [pvt_pkg::COEF_W-1:0]     sinv,
  output logic                                  out_valid,
  output logic signed [COORD_WIDTH+4:0]         rx,
  output logic signed [COORD_WIDTH+4:0]         rz,
  output logic signed [COORD_WIDTH-1:0]         ry
);
  localparam int A = COORD_WIDTH + 1;
  localparam int P = A + pvt_pkg::COEF_W;
  localparam int S = P + 1;
  localparam int T = S - pvt_pkg::FRAC_W;

  logic                   v1, v2;
  logic signed [A-1:0]    dx, dz;
  logic signed [COORD_WIDTH-1:0] vy1, vy2;
  logic signed [P-1:0]    pxc, pzs, pxs, pzc;
  logic signed [S-1:0]    sum_x, sum_z;
  logic signed [T-1:0]    fx, fz;

  assign sum_x = S'(pxc) - S'(pzs);
  assign sum_z = S'(pxs) + S'(pzc);
  // arithmetic shift floors toward minus infinity
  assign fx = T'(sum_x >>> pvt_pkg::FRAC_W);
  assign fz = T'(sum_z >>> pvt_pkg::FRAC_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx  <= A'(vx) - A'(cx);
      dz  <= A'(vz) - A'(cz);
      vy1 <= vy;
      pxc <= dx * cosv;
      pzs <= dz * sinv;
      pxs <= dx * sinv;
      pzc <= dz * cosv;
      vy2 <= vy1;
      rx  <= (COORD_WIDTH+5)'(fx) + (COORD_WIDTH+5)'(cx);
      rz  <= (COORD_WIDTH+5)'(fz) + (COORD_WIDTH+5)'(cz);
      ry  <= vy2;
    end
  end
endmodule

### hdl/pvt_project.sv
// Projection stages 4-6: screen mapping numerators, viewport products and
// the offset that makes the floor division unsigned. Uses pvt_pkg.
module pvt_project #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [COORD_WIDTH+4:0]        rx,
  input  logic signed [COORD_WIDTH+4:0]        rz,
  input  logic signed [COORD_WIDTH-1:0]        ry,
  input  logic [pvt_pkg::SCREEN_W-1:0]         width,
  input  logic [pvt_pkg::SCREEN_W-1:0]         height,
  output logic                                 out_valid,
  output logic                                 invalid,
  output logic signed [COORD_WIDTH+23:0]       num_x,
  output logic signed [COORD_WIDTH+23:0]       num_y,
  output logic signed [COORD_WIDTH+23:0]       den,
  output logic                                 hi_x,
  output logic                                 lo_x,
  output logic                                 hi_y,
  output logic                                 lo_y
);
  localparam int R  = COORD_WIDTH + 5;
  localparam int ZW = R + 1;
  localparam int NW = ZW + pvt_pkg::SCREEN_W + 1;
  localparam int DW = COORD_WIDTH + 24;

  logic                  v4, v5, inv4, inv5;
  logic signed [ZW-1:0]  sx, sy, d4, d5;
  logic signed [NW-1:0]  nx, ny;
  logic signed [DW-1:0]  ox, oy, dd;

  // shift the numerator up by 2^15 divisors so the quotient lands in [0, 2^16)
  assign dd = DW'(d5);
  assign ox = DW'(nx) + (dd <<< (pvt_pkg::QUOT_W - 1));
  assign oy = DW'(ny) + (dd <<< (pvt_pkg::QUOT_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v4 <= in_valid;
      v5 <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx   <= ZW'(rx) + ZW'(rz);
      sy   <= ZW'(rz) - ZW'(ry);
      d4   <= ZW'(rz) <<< 1;
      inv4 <= (rz <= 0);
      nx   <= sx * $signed({1'b0, width});
      ny   <= sy * $signed({1'b0, height});
      d5   <= d4;
      inv5 <= inv4;
      num_x   <= ox;
      num_y   <= oy;
      den     <= dd;
      invalid <= inv5;
      lo_x    <= ox < 0;
      lo_y    <= oy < 0;
      hi_x    <= ox >= (dd <<< pvt_pkg::QUOT_W);
      hi_y    <= oy >= (dd <<< pvt_pkg::QUOT_W);
    end
  end
endmodule

### hdl/pvt_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with saturation
// and the depth-invalid override at the end. Uses pvt_pkg for widths.
module pvt_divider #(
  parameter int DW = 40
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [DW-1:0]                num,
  input  logic signed [DW-1:0]                den,
  input  logic                                hi,
  input  logic                                lo,
  input  logic                                invalid,
  output logic                                out_valid,
  output logic signed [pvt_pkg::PIXEL_W-1:0]  pixel,
  output logic                                out_invalid
);
  localparam int Q = pvt_pkg::QUOT_W;

  logic                 vld [Q+1];
  logic signed [DW-1:0] rem [Q+1];
  logic signed [DW-1:0] dsr [Q+1];
  logic [Q-1:0]         quo [Q+1];
  logic                 fhi [Q+1];
  logic                 flo [Q+1];
  logic                 finv [Q+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = num;
  assign dsr[0]  = den;
  assign quo[0]  = '0;
  assign fhi[0]  = hi;
  assign flo[0]  = lo;
  assign finv[0] = invalid;

  for (genvar k = 0; k < Q; k++) begin : g_stage
    localparam int B = Q - 1 - k;
    logic signed [DW-1:0] trial;
    assign trial = rem[k] - (dsr[k] <<< B);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= (trial >= 0) ? trial : rem[k];
        quo[k+1]  <= quo[k] | ((trial >= 0) ? (Q'(1) << B) : '0);
        dsr[k+1]  <= dsr[k];
        fhi[k+1]  <= fhi[k];
        flo[k+1]  <= flo[k];
        finv[k+1] <= finv[k];
      end
    end
  end

  assign out_valid   = vld[Q];
  assign out_invalid = finv[Q];

  always_comb begin
    priority if (finv[Q]) begin
      pixel = '0;
    end else if (flo[Q]) begin
      pixel = pvt_pkg::PIXEL_MIN;
    end else if (fhi[Q]) begin
      pixel = pvt_pkg::PIXEL_MAX;
    end else begin
      // undo the 2^15 offset
      pixel = $signed(quo[Q] ^ (Q'(1) << (Q - 1)));
    end
  end
endmodule

### hdl/perspective_vertex_transform_top.sv
// Perspective vertex transform: a 6-stage rotate/project front end, two
// 16-stage dividers and an output skid buffer; uses pvt_pkg and the
// channel interfaces.
//
// One vertex beat is taken every cycle while the output is taken and yields
// one pixel beat after 3 rotation, 3 projection and 16 divider stages and
// one output register; the divider stages, one quotient bit each, set the
// latency. When the output stalls, a single skid entry catches the beat in
// flight and the input is held off until it drains. Configuration is
// written over the APB-style port at byte address 4*index; the user must
// write it only while the block is idle, which the block does not enforce.
module perspective_vertex_transform_top #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  pvt_vertex_if.sink                    vertex_in,
  pvt_pixel_if.source                   pixel_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pvt_pkg::ADDR_W-1:0]    paddr,
  input  logic [pvt_pkg::DATA_W-1:0]    pwdata,
  output logic [pvt_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  localparam int DW = COORD_WIDTH + 24;
  localparam int PW = pvt_pkg::PIXEL_W;

  logic signed [pvt_pkg::COEF_W-1:0] cos_reg, sin_reg;
  logic signed [COORD_WIDTH-1:0]     cx_reg, cy_reg, cz_reg;
  logic [pvt_pkg::SCREEN_W-1:0]      w_reg, h_reg;
  pvt_pkg::reg_index_t               idx;

  assign pready = 1'b1;
  assign idx = pvt_pkg::reg_index_t'(paddr[pvt_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_reg <= pvt_pkg::COS_RESET;
      sin_reg <= pvt_pkg::SIN_RESET;
      cx_reg  <= '0;
      cy_reg  <= '0;
      cz_reg  <= COORD_WIDTH'(pvt_pkg::CENTER_Z_RST);
      w_reg   <= pvt_pkg::WIDTH_RESET;
      h_reg   <= pvt_pkg::HEIGHT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (idx)
        pvt_pkg::REG_COS:      cos_reg <= pwdata[pvt_pkg::COEF_W-1:0];
        pvt_pkg::REG_SIN:      sin_reg <= pwdata[pvt_pkg::COEF_W-1:0];
        pvt_pkg::REG_CENTER_X: cx_reg  <= pwdata[COORD_WIDTH-1:0];
        pvt_pkg::REG_CENTER_Y: cy_reg  <= pwdata[COORD_WIDTH-1:0];
        pvt_pkg::REG_CENTER_Z: cz_reg  <= pwdata[COORD_WIDTH-1:0];
        pvt_pkg::REG_WIDTH:    w_reg   <= pwdata[pvt_pkg::SCREEN_W-1:0];
        pvt_pkg::REG_HEIGHT:   h_reg   <= pwdata[pvt_pkg::SCREEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      pvt_pkg::REG_COS:      prdata = pvt_pkg::DATA_W'(unsigned'(cos_reg));
      pvt_pkg::REG_SIN:      prdata = pvt_pkg::DATA_W'(unsigned'(sin_reg));
      pvt_pkg::REG_CENTER_X: prdata = pvt_pkg::DATA_W'(unsigned'(cx_reg));
      pvt_pkg::REG_CENTER_Y: prdata = pvt_pkg::DATA_W'(unsigned'(cy_reg));
      pvt_pkg::REG_CENTER_Z: prdata = pvt_pkg::DATA_W'(unsigned'(cz_reg));
      pvt_pkg::REG_WIDTH:    prdata = pvt_pkg::DATA_W'(w_reg);
      pvt_pkg::REG_HEIGHT:   prdata = pvt_pkg::DATA_W'(h_reg);
      default:               prdata = '0;
    endcase
  end

  // pipeline advances unless the skid entry is occupied
  logic en, skid_valid;
  assign en = !skid_valid;
  assign vertex_in.ready = en;

  logic                          rot_valid;
  logic signed [COORD_WIDTH+4:0] rx, rz;
  logic signed [COORD_WIDTH-1:0] ry;

  pvt_rotate #(.COORD_WIDTH(COORD_WIDTH)) u_rotate (
    .clk, .rst, .en,
    .in_valid (vertex_in.valid),
    .vx (vertex_in.vertex_x), .vy (vertex_in.vertex_y), .vz (vertex_in.vertex_z),
    .cx (cx_reg), .cz (cz_reg), .cosv (cos_reg), .sinv (sin_reg),
    .out_valid (rot_valid), .rx, .rz, .ry
  );

  logic                 prj_valid, prj_inv, hi_x, lo_x, hi_y, lo_y;
  logic signed [DW-1:0] num_x, num_y, den;

  pvt_project #(.COORD_WIDTH(COORD_WIDTH)) u_project (
    .clk, .rst, .en,
    .in_valid (rot_valid), .rx, .rz, .ry,
    .width (w_reg), .height (h_reg),
    .out_valid (prj_valid), .invalid (prj_inv),
    .num_x, .num_y, .den, .hi_x, .lo_x, .hi_y, .lo_y
  );

  logic                 dvx, dvy, inv_x, inv_y;
  logic signed [PW-1:0] px, py;

  pvt_divider #(.DW(DW)) u_div_x (
    .clk, .rst, .en, .in_valid (prj_valid), .num (num_x), .den,
    .hi (hi_x), .lo (lo_x), .invalid (prj_inv),
    .out_valid (dvx), .pixel (px), .out_invalid (inv_x)
  );

  pvt_divider #(.DW(DW)) u_div_y (
    .clk, .rst, .en, .in_valid (prj_valid), .num (num_y), .den,
    .hi (hi_y), .lo (lo_y), .invalid (prj_inv),
    .out_valid (dvy), .pixel (py), .out_invalid (inv_y)
  );

  logic                 dv, dinv;
  logic                 out_valid;
  logic signed [PW-1:0] out_x, out_y, skid_x, skid_y;
  logic                 out_inv, skid_inv;

  assign dv   = dvx && dvy;
  assign dinv = inv_x && inv_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pixel_out.ready) begin
      out_valid  <= skid_valid || dv;
      skid_valid <= 1'b0;
    end else if (dv) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pixel_out.ready) begin
      if (skid_valid) begin
        out_x <= skid_x;  out_y <= skid_y;  out_inv <= skid_inv;
      end else begin
        out_x <= px;  out_y <= py;  out_inv <= dinv;
      end
    end else if (dv && en) begin
      // hold the beat that left the pipeline while the output is stalled
      skid_x <= px;  skid_y <= py;  skid_inv <= dinv;
    end
  end

  assign pixel_out.valid         = out_valid;
  assign pixel_out.pixel_x       = out_x;
  assign pixel_out.pixel_y       = out_y;
  assign pixel_out.depth_invalid = out_inv;
endmodule

### hdl/pvt_checker.sv
// Port-level checks for the perspective vertex transform, bound to the top
// level. Depends on pvt_pkg for the pixel width.
module pvt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [pvt_pkg::PIXEL_W-1:0]  pixel_x,
  input logic [pvt_pkg::PIXEL_W-1:0]  pixel_y,
  input logic                         depth_invalid
);
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat right after reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && depth_invalid |-> pixel_x == '0 && pixel_y == '0)
    else $error("invalid depth with nonzero pixel");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input held off with no output beat pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y))
    else $error("stalled output beat changed");
endmodule

bind perspective_vertex_transform_top pvt_checker u_pvt_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (vertex_in.ready),
  .out_valid     (pixel_out.valid),
  .out_ready     (pixel_out.ready),
  .pixel_x       (pixel_out.pixel_x),
  .pixel_y       (pixel_out.pixel_y),
  .depth_invalid (pixel_out.depth_invalid)
);
